### rtl/core/kst_pkg.sv
`timescale 1ns / 1ps

package kst_pkg;

  localparam int ID_W     = 64;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 8;
  localparam int DATA_W   = 64;
  localparam int CODE_W   = 3;
  localparam int HIT_W    = 4;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_CLEAR  = 2'd3
  } act_t;

  typedef enum logic [CODE_W-1:0] {
    RES_UPDATED   = 3'd0,
    RES_INSERTED  = 3'd1,
    RES_REPLACED  = 3'd2,
    RES_READ_HIT  = 3'd3,
    RES_READ_MISS = 3'd4,
    RES_READ_BAD  = 3'd5,
    RES_DELETED   = 3'd6,
    RES_DEL_MISS  = 3'd7
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_FINISH
  } st_t;

  // One table entry as it sits in the memory.
  typedef struct packed {
    logic [ID_W-1:0]            client;
    logic [ID_W-1:0]            server;
    logic signed [KEY_W-1:0]    key_id;
    logic [STATUS_W-1:0]        status;
    logic [DATA_W-1:0]          data;
  } entry_t;

  // Zero every byte from the first zero byte upward.
  function automatic logic [ID_W-1:0] canon_id(input logic [ID_W-1:0] v);
    logic [ID_W-1:0] r;
    logic            live;
    r    = '0;
    live = 1'b1;
    for (int i = 0; i < 8; i++) begin
      live = live && (v[8*i +: 8] != 8'd0);
      if (live) begin
        r[8*i +: 8] = v[8*i +: 8];
      end
    end
    return r;
  endfunction

  function automatic logic id_empty(input logic [ID_W-1:0] v);
    return v[7:0] == 8'd0;
  endfunction

endpackage

### rtl/core/kst_in_if.sv
`timescale 1ns / 1ps

interface kst_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [63:0]         client_id;
  logic [63:0]         server_id;
  logic signed [31:0]  key_id;
  logic [7:0]          status_in;
  logic [63:0]         key_data;

  modport source (
    output valid, action, client_id, server_id, key_id, status_in, key_data,
    input  ready
  );

  modport sink (
    input  valid, action, client_id, server_id, key_id, status_in, key_data,
    output ready
  );
endinterface

### rtl/core/kst_out_if.sv
`timescale 1ns / 1ps

interface kst_out_if;
  logic                valid;
  logic                ready;
  logic [2:0]          result_code;
  logic [3:0]          hit_index;
  logic signed [31:0]  out_key_id;
  logic [7:0]          out_status;
  logic [63:0]         out_key_data;

  modport source (
    output valid, result_code, hit_index, out_key_id, out_status, out_key_data,
    input  ready
  );

  modport sink (
    input  valid, result_code, hit_index, out_key_id, out_status, out_key_data,
    output ready
  );
endinterface

### rtl/core/kst_ram.sv
`timescale 1ns / 1ps

module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/keyed_session_table_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Word carried
// -------  ---  ---------------------------------------------------------------
// req      in   action, client_id, server_id, key_id, status_in, key_data
// rsp      out  result_code, hit_index, out_key_id, out_status, out_key_data
//
// A write, read or delete scans the table one entry per cycle through the
// single read port of the entry memory, and the scan ends early on a hit.
// A clear or a rejected read skips the scan and goes straight to finish.
// Reset and clear empty the table at once through per-entry valid bits; an
// entry whose valid bit is low reads as all zero. The request side is ready
// only while no word is in work; a finished result waits in the output
// register, so a stalled rsp delays only the next result hand-off.

module keyed_session_table_unit #(
  parameter int NODES = 16
) (
  input  logic      clk,
  input  logic      rst,
  kst_in_if.sink    req,
  kst_out_if.source rsp
);
  import kst_pkg::*;

  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW = $clog2(NODES + 1);
  localparam logic [IW-1:0] LAST = IW'(NODES - 1);
  localparam int ENTRY_W = $bits(entry_t);

  st_t state, state_next;

  // Latched request. Ids are kept in canonical form so that stored entries
  // compare with a plain equality.
  act_t   rq_act;
  entry_t rq;

  // Scan pipeline: one address issued per cycle, compared in the cycle after.
  logic [CW-1:0] issue_cnt;
  logic          cmp_valid;
  logic [IW-1:0] cmp_idx;
  logic          found;
  logic [IW-1:0] hit_idx;
  logic          empty_found;
  logic [IW-1:0] empty_idx;

  logic [NODES-1:0] valid_bits;
  entry_t           ram_q;
  entry_t           ent;

  // Result waiting for the output register.
  res_t                 res_code;
  logic [IW-1:0]        res_idx;
  logic signed [31:0]   res_key;
  logic [7:0]           res_status;
  logic [63:0]          res_data;
  logic [IW+3:0]        idx_wide;

  logic req_fire;
  logic issue_en;
  logic hit_now;
  logic scan_done;
  logic ent_empty;
  logic ids_eq;
  logic c_ne;
  logic s_ne;
  logic read_bad;
  logic out_free;
  logic ram_we;
  logic [IW-1:0] wr_idx;

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;

  // A read is rejected when an id is empty or the key id is not positive.
  assign read_bad = id_empty(req.client_id) || id_empty(req.server_id) ||
                    (req.key_id <= 32'sd0);

  assign issue_en = (state == ST_SCAN) && (issue_cnt < CW'(NODES)) && !found;

  kst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (rq),
    .raddr (issue_cnt[IW-1:0]),
    .rdata (ram_q)
  );

  // Compare stage.
  assign ent       = valid_bits[cmp_idx] ? ram_q : '0;
  assign c_ne      = !id_empty(ent.client);
  assign s_ne      = !id_empty(ent.server);
  assign ids_eq    = (ent.client == rq.client) && (ent.server == rq.server);
  assign ent_empty = !c_ne && !s_ne;

  always_comb begin
    hit_now = 1'b0;
    if (cmp_valid && !found && (state == ST_SCAN)) begin
      unique case (rq_act)
        ACT_WRITE:  hit_now = c_ne && s_ne && ids_eq;
        ACT_READ:   hit_now = c_ne && ids_eq && (ent.key_id == rq.key_id);
        ACT_DELETE: hit_now = c_ne && ids_eq && (ent.key_id == rq.key_id) &&
                              (ent.status == rq.status);
        default:    hit_now = 1'b0;
      endcase
    end
  end

  assign scan_done = hit_now || (cmp_valid && (cmp_idx == LAST));

  // Where a write lands: its own entry, else the first empty one, else the last.
  always_comb begin
    priority if (found) begin
      wr_idx = hit_idx;
    end else if (empty_found) begin
      wr_idx = empty_idx;
    end else begin
      wr_idx = LAST;
    end
  end

  assign ram_we = (state == ST_COMMIT) && (rq_act == ACT_WRITE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          if ((act_t'(req.action) == ACT_CLEAR) ||
              ((act_t'(req.action) == ACT_READ) && read_bad)) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Request latch and scan bookkeeping. The compare stage goes idle as soon
  // as the scan ends, so nothing is left pending once the word commits.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      rq_act    <= act_t'(req.action);
      rq.client <= canon_id(req.client_id);
      rq.server <= canon_id(req.server_id);
      rq.key_id <= req.key_id;
      rq.status <= req.status_in;
      rq.data   <= req.key_data;
    end
    if (rst) begin
      issue_cnt   <= '0;
      cmp_valid   <= 1'b0;
      found       <= 1'b0;
      empty_found <= 1'b0;
    end else if (req_fire) begin
      issue_cnt   <= '0;
      cmp_valid   <= 1'b0;
      found       <= 1'b0;
      empty_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      cmp_valid <= issue_en && !scan_done;
      if (issue_en) begin
        issue_cnt <= issue_cnt + CW'(1);
      end
      if (hit_now) begin
        found <= 1'b1;
      end
      if (cmp_valid && !empty_found && ent_empty) begin
        empty_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_en) begin
      cmp_idx <= issue_cnt[IW-1:0];
    end
    if (hit_now) begin
      hit_idx <= cmp_idx;
    end
    if ((state == ST_SCAN) && cmp_valid && !empty_found && ent_empty) begin
      empty_idx <= cmp_idx;
    end
  end

  // Valid bits: reset and clear empty the table at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (req_fire && (act_t'(req.action) == ACT_CLEAR)) begin
      valid_bits <= '0;
    end else if (ram_we) begin
      valid_bits[wr_idx] <= 1'b1;
    end else if ((state == ST_COMMIT) && (rq_act == ACT_DELETE) && found) begin
      valid_bits[hit_idx] <= 1'b0;
    end
  end

  // Result assembly.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      res_idx    <= '0;
      res_status <= '0;
      res_data   <= '0;
      if (act_t'(req.action) == ACT_READ) begin
        res_code <= RES_READ_BAD;
        res_key  <= -32'sd1;
      end else begin
        res_code <= RES_UPDATED;
        res_key  <= '0;
      end
    end else if (hit_now && (rq_act == ACT_READ)) begin
      res_key    <= ent.key_id;
      res_status <= ent.status;
      res_data   <= ent.data;
    end else if (state == ST_COMMIT) begin
      unique case (rq_act)
        ACT_WRITE: begin
          res_idx <= wr_idx;
          priority if (found) begin
            res_code <= RES_UPDATED;
          end else if (empty_found) begin
            res_code <= RES_INSERTED;
          end else begin
            res_code <= RES_REPLACED;
          end
        end
        ACT_READ: begin
          if (found) begin
            res_code <= RES_READ_HIT;
            res_idx  <= hit_idx;
          end else begin
            res_code <= RES_READ_MISS;
          end
        end
        ACT_DELETE: begin
          if (found) begin
            res_code <= RES_DELETED;
            res_idx  <= hit_idx;
          end else begin
            res_code <= RES_DEL_MISS;
          end
        end
        default: begin
          res_code <= RES_UPDATED;
        end
      endcase
    end
  end

  // The hit index field carries the low four bits of the entry index.
  assign idx_wide = {4'b0000, res_idx};

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      rsp.result_code  <= res_code;
      rsp.hit_index    <= idx_wide[3:0];
      rsp.out_key_id   <= res_key;
      rsp.out_status   <= res_status;
      rsp.out_key_data <= res_data;
    end
  end

  // A clear leaves every entry empty on the next cycle.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (req_fire && (act_t'(req.action) == ACT_CLEAR)) |=> (valid_bits == '0))
    else $error("clear did not empty the table");

  // A committed write marks its target entry as valid.
  a_write_marks: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> valid_bits[$past(wr_idx)])
    else $error("written entry not marked valid");

  // Compares happen only while scanning, never while a word is being accepted.
  a_cmp_in_scan: assert property (@(posedge clk) disable iff (rst)
    (cmp_valid && (state != ST_SCAN)) |-> !req.ready)
    else $error("compare stage active while accepting");

  // A read that misses or is rejected reports key id -1.
  a_miss_key: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && ((rsp.result_code == RES_READ_MISS) ||
                   (rsp.result_code == RES_READ_BAD))) |-> (rsp.out_key_id == -32'sd1))
    else $error("read miss without key id -1");

  // A scan that found its entry ends on the next cycle.
  a_hit_ends_scan: assert property (@(posedge clk) disable iff (rst)
    hit_now |=> (state == ST_COMMIT))
    else $error("scan continued after a hit");

endmodule

### tb/kst_reply_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the keyed session table, keeps its own copy of the
// table, and checks every response word against the outcome it predicts.
module kst_reply_checker #(
  parameter int NODES = 16
) (
  input  logic clk,
  input  logic rst,
  kst_in_if    req,
  kst_out_if   rsp,
  output int   mismatch_count,
  output int   replies_pending
);

  import kst_pkg::*;

  typedef struct packed {
    logic [63:0]        client;
    logic [63:0]        server;
    logic signed [31:0] key_id;
    logic [7:0]         status;
    logic [63:0]        data;
  } slot_t;

  typedef struct packed {
    res_t               code;
    logic [3:0]         index;
    logic signed [31:0] key_id;
    logic [7:0]         status;
    logic [63:0]        data;
  } reply_t;

  slot_t  slots [NODES];
  reply_t awaited_replies [$];

  // Keeps the characters up to the first zero byte and clears the rest.
  function automatic logic [63:0] squeeze_id(input logic [63:0] raw);
    logic [63:0] kept;
    int          n;
    kept = '0;
    n    = 0;
    while (n < 8 && raw[8*n +: 8] != 8'h00) begin
      kept[8*n +: 8] = raw[8*n +: 8];
      n++;
    end
    return kept;
  endfunction

  // Applies one request to the local table and returns the response it earns.
  function automatic reply_t session_table_apply(input act_t op,
                                                 input logic [63:0] cid_raw,
                                                 input logic [63:0] sid_raw,
                                                 input logic signed [31:0] kid,
                                                 input logic [7:0] st,
                                                 input logic [63:0] payload);
    logic [63:0] cid;
    logic [63:0] sid;
    reply_t      r;
    int          hit;
    int          i;
    cid = squeeze_id(cid_raw);
    sid = squeeze_id(sid_raw);
    r   = '0;
    hit = -1;
    case (op)
      ACT_WRITE: begin
        for (i = 0; i < NODES; i++) begin
          if (hit < 0 && slots[i].client[7:0] != 8'h00 && slots[i].server[7:0] != 8'h00 &&
              slots[i].client == cid && slots[i].server == sid) begin
            hit = i;
          end
        end
        r.code = RES_UPDATED;
        if (hit < 0) begin
          for (i = 0; i < NODES; i++) begin
            if (hit < 0 && slots[i].client[7:0] == 8'h00 && slots[i].server[7:0] == 8'h00) begin
              hit = i;
            end
          end
          r.code = RES_INSERTED;
        end
        if (hit < 0) begin
          hit    = NODES - 1;
          r.code = RES_REPLACED;
        end
        slots[hit] = '{client: cid, server: sid, key_id: kid, status: st, data: payload};
        r.index    = hit[3:0];
      end
      ACT_READ: begin
        r.key_id = -32'sd1;
        if (cid[7:0] == 8'h00 || sid[7:0] == 8'h00 || kid <= 0) begin
          r.code = RES_READ_BAD;
        end else begin
          r.code = RES_READ_MISS;
          for (i = 0; i < NODES; i++) begin
            if (hit < 0 && slots[i].client[7:0] != 8'h00 && slots[i].client == cid &&
                slots[i].server == sid && slots[i].key_id == kid) begin
              hit = i;
            end
          end
          if (hit >= 0) begin
            r.code   = RES_READ_HIT;
            r.index  = hit[3:0];
            r.key_id = slots[hit].key_id;
            r.status = slots[hit].status;
            r.data   = slots[hit].data;
          end
        end
      end
      ACT_DELETE: begin
        r.code = RES_DEL_MISS;
        for (i = 0; i < NODES; i++) begin
          if (hit < 0 && slots[i].client[7:0] != 8'h00 && slots[i].client == cid &&
              slots[i].server == sid && slots[i].key_id == kid && slots[i].status == st) begin
            hit = i;
          end
        end
        if (hit >= 0) begin
          slots[hit] = '0;
          r.code     = RES_DELETED;
          r.index    = hit[3:0];
        end
      end
      default: begin
        for (i = 0; i < NODES; i++) begin
          slots[i] = '0;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    int     bad;
    int     i;
    bad = 0;
    if (rst) begin
      for (i = 0; i < NODES; i++) begin
        slots[i] = '0;
      end
      awaited_replies.delete();
      replies_pending <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_replies.size() == 0) begin
          $error("response word arrived with nothing outstanding");
          bad++;
        end else begin
          want = awaited_replies.pop_front();
          if (rsp.result_code !== want.code) begin
            $error("result_code: expected %0d, got %0d", want.code, rsp.result_code);
            bad++;
          end
          if (rsp.hit_index !== want.index) begin
            $error("hit_index: expected %0d, got %0d", want.index, rsp.hit_index);
            bad++;
          end
          if (rsp.out_key_id !== want.key_id) begin
            $error("out_key_id: expected %0d, got %0d", want.key_id, rsp.out_key_id);
            bad++;
          end
          if (rsp.out_status !== want.status) begin
            $error("out_status: expected %0d, got %0d", want.status, rsp.out_status);
            bad++;
          end
          if (rsp.out_key_data !== want.data) begin
            $error("out_key_data: expected %h, got %h", want.data, rsp.out_key_data);
            bad++;
          end
        end
      end
      if (req.valid && req.ready) begin
        awaited_replies.push_back(session_table_apply(act_t'(req.action), req.client_id,
                                                      req.server_id, req.key_id,
                                                      req.status_in, req.key_data));
      end
      replies_pending <= awaited_replies.size();
    end
    mismatch_count <= mismatch_count + bad;
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

// Top of the keyed session table bench. This module only makes request words,
// paces both channels and gives the verdict; all prediction and comparison
// lives in the reply checker instantiated beside the block.
module tb;

  import kst_pkg::*;

  localparam int NODES        = 16;
  localparam int NAME_POOL    = 24;      // more pairs than entries, so the table fills
  localparam int RANDOM_WORDS = 1730;
  localparam int CYCLE_LIMIT  = 400000;  // many times the slowest legal run
  localparam int DRAIN_CYCLES = 40;

  // Ids are packed low byte first, so the first character is bits 7:0.
  localparam logic [63:0] CLI_A     = 64'h0000_0000_0000_4341;  // "AC"
  localparam logic [63:0] SRV_B     = 64'h0000_0000_0042_5253;  // "SRB"
  localparam logic [63:0] CLI_C     = 64'h0000_0000_0000_0063;  // "c"
  localparam logic [63:0] SRV_D     = 64'h0000_0000_6464_6464;  // "dddd"
  localparam logic [63:0] TAIL_JUNK = 64'hdead_be12_0000_0000;  // lands past the zero byte
  localparam logic [63:0] EMPTY_JNK = 64'h5a5a_5a5a_5a5a_5a00;  // empty, junk behind
  localparam logic [63:0] FULL_ONES = 64'hffff_ffff_ffff_ffff;  // eight 0xff characters
  localparam logic [63:0] FULL_SEQ  = 64'h0102_0304_0506_0708;  // eight characters

  logic clk;
  logic rst;

  kst_in_if  req_ch ();
  kst_out_if rsp_ch ();

  int mismatch_count;
  int replies_pending;

  // Idling switches, turned off together for one long stretch of the run.
  logic send_gaps_on;
  logic stall_on;

  logic [63:0] client_names [NAME_POOL];
  logic [63:0] server_names [NAME_POOL];

  int unsigned cycle_count;

  keyed_session_table_unit #(.NODES(NODES)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  kst_reply_checker #(.NODES(NODES)) checker_i (
    .clk             (clk),
    .rst             (rst),
    .req             (req_ch),
    .rsp             (rsp_ch),
    .mismatch_count  (mismatch_count),
    .replies_pending (replies_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The response side drops ready at random, 16 times in a hundred, while idling is on.
  always @(posedge clk) begin
    rsp_ch.ready <= !(stall_on && $urandom_range(0, 99) < 16);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // A fresh id of one to eight characters; every byte value but zero occurs.
  function automatic logic [63:0] fresh_name();
    logic [63:0] id;
    int          len;
    int          j;
    id  = '0;
    len = $urandom_range(1, 8);
    for (j = 0; j < len; j++) begin
      id[8*j +: 8] = 8'($urandom_range(1, 255));
    end
    return id;
  endfunction

  // Fills every byte behind the first zero byte with junk. The block must
  // treat the result as the same id, since only the leading characters count.
  function automatic logic [63:0] smear_tail(input logic [63:0] id);
    logic [63:0] out;
    int          j;
    logic        past_zero;
    out       = id;
    past_zero = 1'b0;
    for (j = 0; j < 8; j++) begin
      if (past_zero) begin
        out[8*j +: 8] = 8'($urandom_range(0, 255));
      end else if (id[8*j +: 8] == 8'h00) begin
        past_zero = 1'b1;
      end
    end
    return out;
  endfunction

  // Key ids cluster on a few small values so that reads and deletes hit;
  // the rest covers zero, negatives, both extremes and arbitrary values.
  function automatic logic signed [31:0] pick_key();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 14) begin
      return 32'sd1 + $urandom_range(0, 2);
    end else if (roll == 14) begin
      return 32'sh7fff_ffff;
    end else if (roll == 15) begin
      return 32'sd0;
    end else if (roll == 16) begin
      return -32'sd1;
    end else if (roll == 17) begin
      return 32'sh8000_0000;
    end
    return $urandom;
  endfunction

  // Status likewise sits mostly on a few values so that deletes can match.
  function automatic logic [7:0] pick_status();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) begin
      return 8'h00;
    end else if (roll < 6) begin
      return 8'h01;
    end else if (roll < 8) begin
      return 8'hff;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Presents one request word and holds it until the block takes it. Ready is
  // sampled right after the edge, so it is the value the edge itself saw. When
  // no gap is taken, valid simply stays high into the next word.
  task automatic send_word(input act_t op, input logic [63:0] cid, input logic [63:0] sid,
                           input logic signed [31:0] kid, input logic [7:0] st,
                           input logic [63:0] payload);
    if (send_gaps_on && $urandom_range(0, 99) < 16) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.action    <= op;
    req_ch.client_id <= cid;
    req_ch.server_id <= sid;
    req_ch.key_id    <= kid;
    req_ch.status_in <= st;
    req_ch.key_data  <= payload;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Stops sending and waits for every outstanding response. The first edge
  // lets the checker's count take in a word accepted at the last edge.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (replies_pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [63:0] cid;
    logic [63:0] sid;
    int          span;
    int          roll;
    int          p;
    act_t        op;

    send_gaps_on = 1'b1;
    stall_on     = 1'b1;
    span         = NAME_POOL;
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.action    <= ACT_WRITE;
    req_ch.client_id <= '0;
    req_ch.server_id <= '0;
    req_ch.key_id    <= '0;
    req_ch.status_in <= '0;
    req_ch.key_data  <= '0;
    for (int k = 0; k < NAME_POOL; k++) begin
      client_names[k] = fresh_name();
      server_names[k] = fresh_name();
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- Directed words ----
    // Lookups against an empty table: a plain miss, then every reason a read
    // is rejected outright (empty client, empty server, zero key, negative key).
    send_word(ACT_READ, CLI_A, SRV_B, 32'sd1, 8'h00, '0);
    send_word(ACT_READ, EMPTY_JNK, SRV_B, 32'sd1, 8'h00, '0);
    send_word(ACT_READ, CLI_A, 64'h0, 32'sd1, 8'h00, '0);
    send_word(ACT_READ, CLI_A, SRV_B, 32'sd0, 8'h00, '0);
    send_word(ACT_READ, CLI_A, SRV_B, 32'sh8000_0000, 8'h00, '0);
    // First write inserts at entry 0 with every payload extreme.
    send_word(ACT_WRITE, CLI_A, SRV_B, 32'sh7fff_ffff, 8'hff, FULL_ONES);
    // Same ids with junk behind the terminator must update entry 0 in place.
    send_word(ACT_WRITE, CLI_A | TAIL_JUNK, SRV_B | TAIL_JUNK, 32'sd7, 8'h00, 64'h0);
    send_word(ACT_READ, CLI_A | TAIL_JUNK, SRV_B, 32'sd7, 8'h00, '0);
    send_word(ACT_READ, CLI_A, SRV_B, 32'sh7fff_ffff, 8'h00, '0);
    // A write with empty ids is stored, yet the entry still counts as free,
    // so the next new pair lands on the same index.
    send_word(ACT_WRITE, EMPTY_JNK, EMPTY_JNK, 32'sd3, 8'h42, 64'h0123_4567_89ab_cdef);
    send_word(ACT_WRITE, CLI_C, SRV_D, -32'sd5, 8'h80, 64'hfedc_ba98_7654_3210);
    // Delete needs the status to match too: first a near miss, then the hit.
    send_word(ACT_DELETE, CLI_C, SRV_D, -32'sd5, 8'h81, '0);
    send_word(ACT_DELETE, CLI_C, SRV_D, -32'sd5, 8'h80, '0);
    // A client with an empty server is neither free nor updatable, so the
    // second identical write takes a fresh entry. Reading it is rejected,
    // but delete only asks for a nonempty client and finds it.
    send_word(ACT_WRITE, CLI_C, 64'h0, 32'sd9, 8'h10, 64'h1);
    send_word(ACT_WRITE, CLI_C, 64'h0, 32'sd9, 8'h10, 64'h2);
    send_word(ACT_READ, CLI_C, 64'h0, 32'sd9, 8'h10, '0);
    send_word(ACT_DELETE, CLI_C, EMPTY_JNK, 32'sd9, 8'h10, '0);
    // Clear with junk in every other field, then the old pair is gone.
    send_word(ACT_CLEAR, FULL_ONES, FULL_SEQ, $urandom, 8'($urandom_range(0, 255)),
              {$urandom, $urandom});
    send_word(ACT_READ, CLI_A, SRV_B, 32'sd7, 8'h00, '0);
    // Ids using all eight characters, including the all-0xff pattern.
    send_word(ACT_WRITE, FULL_ONES, FULL_SEQ, 32'sd1, 8'h5a, {$urandom, $urandom});
    send_word(ACT_READ, FULL_ONES, FULL_SEQ, 32'sd1, 8'h00, '0);

    // The sender holds off until every response is back before going on.
    drain();

    // ---- Random words ----
    // Mostly well-formed traffic over a small set of id pairs, so writes
    // update, reads hit and deletes find their entries. Now and then the pool
    // grows past the table size, which forces replacement of the last entry.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 96 == 0) begin
        span = ($urandom_range(0, 2) == 0) ? NAME_POOL : $urandom_range(2, 8);
      end
      send_gaps_on = !(n >= 700 && n < 1000);
      stall_on     = !(n >= 700 && n < 1000);
      if (n == 1200) begin
        drain();
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        // Noise: any action with arbitrary bits in every field.
        op = act_t'($urandom_range(0, 3));
        send_word(op, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                  8'($urandom_range(0, 255)), {$urandom, $urandom});
      end else if (roll < 6) begin
        send_word(ACT_CLEAR, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                  8'($urandom_range(0, 255)), {$urandom, $urandom});
      end else begin
        p   = $urandom_range(0, span - 1);
        cid = client_names[p];
        sid = ($urandom_range(0, 9) == 0) ? server_names[$urandom_range(0, span - 1)]
                                           : server_names[p];
        if ($urandom_range(0, 3) == 0) begin
          cid = smear_tail(cid);
        end
        if ($urandom_range(0, 3) == 0) begin
          sid = smear_tail(sid);
        end
        if ($urandom_range(0, 39) == 0) begin
          cid = {$urandom, $urandom} & ~64'hff;
        end
        if ($urandom_range(0, 39) == 0) begin
          sid = {$urandom, $urandom} & ~64'hff;
        end
        op = (roll < 46) ? ACT_WRITE : (roll < 80) ? ACT_READ : ACT_DELETE;
        send_word(op, cid, sid, pick_key(), pick_status(), {$urandom, $urandom});
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
